### rtl/core/skt_pkg.sv
`default_nettype none

package skt_pkg;

  // Operation codes carried on the request channel
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // Width of the record count field on the result channel
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        score;
  } record_t;

endpackage

`default_nettype wire

### rtl/core/skt_if.sv
`default_nettype none

// Request channel
interface skt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] key;
  logic [31:0]        score;

  modport source (output valid, output operation, output key, output score, input ready);
  modport sink (input valid, input operation, input key, input score, output ready);
endinterface

// Result channel
interface skt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] rec_key;
  logic [31:0]        rec_score;
  logic [4:0]         record_count;
  logic               last;

  modport source (output valid, output status, output rec_key, output rec_score,
                  output record_count, output last, input ready);
  modport sink (input valid, input status, input rec_key, input rec_score,
                input record_count, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/sorted_key_table.sv
// Sorted key table: holds up to DEPTH records (signed key, 32-bit score) in
// ascending key order, in one single-port-write, single-port-read memory.
// Request channel in_i: operation insert, delete by key, or dump. Result
// channel out_o: one result per insert or delete, one result per record on
// a dump (last set on the final one), or one empty result for a dump of an
// empty table. record_count reports the records held after the operation.
// One shared compare unit walks the memory, one entry per cycle. An
// insert walks from the top entry down to its slot and moves each larger
// or equal entry up as it goes. A delete scans all count entries, closing
// the gap behind the match. A dump streams one record per cycle while the
// receiver takes them. Full and empty cases are answered from the idle
// state without a walk; an unused operation code is dropped.
// A new request is taken only while the sequencer is idle and the result
// register is empty or being drained in that cycle.
// Reset clears the record count and the sequencer; memory contents are
// not cleared, since entries past the count are never read.
// When the receiver stalls, the result register holds its transaction and
// a dump pauses on the current record until it is taken.
`default_nettype none

module sorted_key_table import skt_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  skt_in_if.sink     in_i,
  skt_out_if.source  out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PLACE,
    S_DEL,
    S_DUMP
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               found_q, found_d;
  logic signed [31:0] key_q, key_d;
  logic [31:0]        score_q, score_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic signed [31:0] out_key_q, out_key_d;
  logic [31:0]        out_score_q, out_score_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic               out_last_q, out_last_d;

  logic               we;
  logic [AW-1:0]      waddr;
  record_t            wdata;
  logic [AW-1:0]      raddr;
  record_t            rdata;

  logic               out_free;
  logic               in_ready;
  logic [CW-1:0]      cnt_p1;
  logic [CW-1:0]      cnt_m1;
  logic [AW-1:0]      top_idx;
  logic               at_end;
  logic               key_ge;
  logic               key_eq;

  skt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign cnt_p1   = CW'(cnt_q + 1'b1);
  assign cnt_m1   = CW'(cnt_q - 1'b1);
  assign top_idx  = cnt_m1[AW-1:0];
  assign at_end   = (CW'(idx_q) == cnt_m1);

  // Shared compare unit on the entry read last cycle
  assign key_ge = ($signed(rdata.key) >= key_q);
  assign key_eq = (rdata.key == key_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    key_d       = key_q;
    score_d     = score_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_key_d   = out_key_q;
    out_score_d = out_score_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata;
    raddr       = idx_q;
    in_ready    = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready = out_free;
        if (in_i.valid && out_free) begin
          key_d   = in_i.key;
          score_d = in_i.score;
          case (in_i.operation)
            OP_INSERT: begin
              if (cnt_q >= CW'(DEPTH)) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_FULL;
                out_key_d    = in_i.key;
                out_score_d  = '0;
                out_count_d  = COUNT_W'(cnt_q);
                out_last_d   = 1'b1;
              end else if (cnt_q == '0) begin
                // Empty table: write straight to the first slot
                we           = 1'b1;
                waddr        = '0;
                wdata        = '{key: in_i.key, score: in_i.score};
                cnt_d        = cnt_p1;
                out_valid_d  = 1'b1;
                out_status_d = ST_OK;
                out_key_d    = in_i.key;
                out_score_d  = '0;
                out_count_d  = COUNT_W'(cnt_p1);
                out_last_d   = 1'b1;
              end else begin
                idx_d   = top_idx;
                raddr   = top_idx;
                state_d = S_INS;
              end
            end
            OP_DELETE: begin
              if (cnt_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_NOT_FOUND;
                out_key_d    = in_i.key;
                out_score_d  = '0;
                out_count_d  = COUNT_W'(cnt_q);
                out_last_d   = 1'b1;
              end else begin
                idx_d   = '0;
                raddr   = '0;
                found_d = 1'b0;
                state_d = S_DEL;
              end
            end
            OP_DUMP: begin
              if (cnt_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_EMPTY;
                out_key_d    = in_i.key;
                out_score_d  = '0;
                out_count_d  = '0;
                out_last_d   = 1'b1;
              end else begin
                idx_d   = '0;
                raddr   = '0;
                state_d = S_DUMP;
              end
            end
            default: begin
              // Unused code: drop the transaction
            end
          endcase
        end
      end

      S_INS: begin
        // Walk down: move larger-or-equal entries up one slot
        we    = 1'b1;
        waddr = AW'(idx_q + 1'b1);
        if (key_ge) begin
          wdata = rdata;
          if (idx_q == '0) begin
            state_d = S_PLACE;
          end else begin
            idx_d = AW'(idx_q - 1'b1);
            raddr = AW'(idx_q - 1'b1);
          end
        end else begin
          wdata        = '{key: key_q, score: score_q};
          cnt_d        = cnt_p1;
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_key_d    = key_q;
          out_score_d  = '0;
          out_count_d  = COUNT_W'(cnt_p1);
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_PLACE: begin
        // New record goes to the bottom slot
        we           = 1'b1;
        waddr        = '0;
        wdata        = '{key: key_q, score: score_q};
        cnt_d        = cnt_p1;
        out_valid_d  = 1'b1;
        out_status_d = ST_OK;
        out_key_d    = key_q;
        out_score_d  = '0;
        out_count_d  = COUNT_W'(cnt_p1);
        out_last_d   = 1'b1;
        state_d      = S_IDLE;
      end

      S_DEL: begin
        // Walk up: after the first match, move each entry down one slot
        if (found_q) begin
          we    = 1'b1;
          waddr = AW'(idx_q - 1'b1);
          wdata = rdata;
        end else if (key_eq) begin
          found_d = 1'b1;
        end
        if (at_end) begin
          out_valid_d = 1'b1;
          out_key_d   = key_q;
          out_score_d = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
          if (found_q || key_eq) begin
            cnt_d        = cnt_m1;
            out_status_d = ST_OK;
            out_count_d  = COUNT_W'(cnt_m1);
          end else begin
            out_status_d = ST_NOT_FOUND;
            out_count_d  = COUNT_W'(cnt_q);
          end
        end else begin
          idx_d = AW'(idx_q + 1'b1);
          raddr = AW'(idx_q + 1'b1);
        end
      end

      S_DUMP: begin
        // Stream one record per free result slot; hold the read otherwise
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_key_d    = rdata.key;
          out_score_d  = rdata.score;
          out_count_d  = COUNT_W'(cnt_q);
          out_last_d   = at_end;
          if (at_end) begin
            state_d = S_IDLE;
          end else begin
            idx_d = AW'(idx_q + 1'b1);
            raddr = AW'(idx_q + 1'b1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      key_q        <= '0;
      score_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_key_q    <= '0;
      out_score_q  <= '0;
      out_count_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      found_q      <= found_d;
      key_q        <= key_d;
      score_q      <= score_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_key_q    <= out_key_d;
      out_score_q  <= out_score_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.rec_key      = out_key_q;
  assign out_o.rec_score    = out_score_q;
  assign out_o.record_count = out_count_q;
  assign out_o.last         = out_last_q;

endmodule

`default_nettype wire

### rtl/core/skt_store.sv
`default_nettype none

module skt_store import skt_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire record_t       wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output record_t            rdata_o
);

  record_t mem_q [DEPTH];
  record_t rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/skt_checker.sv
`default_nettype none

module skt_checker import skt_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [1:0]         status_i,
  input wire logic signed [31:0] rec_key_i,
  input wire logic [31:0]        rec_score_i,
  input wire logic [4:0]         record_count_i,
  input wire logic               last_i
);

  // A full refusal reports a table holding DEPTH records
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |-> record_count_i == COUNT_W'(DEPTH))
    else $error("full status with record count not at capacity");

  // An empty dump reports zero records, zero score, and ends the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY) |->
      (record_count_i == '0) && (rec_score_i == '0) && last_i)
    else $error("empty status with inconsistent fields");

  // Only dump records come without last, and those are always ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> (status_i == ST_OK) && (record_count_i != '0))
    else $error("non-final result with bad status or zero count");

  // A stalled result holds its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(rec_key_i) && $stable(rec_score_i) && $stable(record_count_i) &&
      $stable(last_i))
    else $error("result changed while stalled");

endmodule

bind sorted_key_table skt_checker #(
  .DEPTH (DEPTH)
) u_skt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .rec_key_i      (out_o.rec_key),
  .rec_score_i    (out_o.rec_score),
  .record_count_i (out_o.record_count),
  .last_i         (out_o.last)
);

`default_nettype wire
